// ===== rtl/sbfa_pkg.sv =====
// shared types and constants for the segregated best-fit allocator
// no dependencies; used by sbfa_seq and the top level
package sbfa_pkg;

	// request kinds on the slave tuser field
	localparam logic [1:0] REQ_ALLOC    = 2'd0;
	localparam logic [1:0] REQ_FREE     = 2'd1;
	localparam logic [1:0] REQ_FREE_ALL = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_OOM = 2'd1;
	localparam logic [1:0] STAT_IGN = 2'd2;

	// chunk geometry
	localparam int unsigned MIN_CHUNK   = 16;
	localparam int unsigned CHUNK_SHIFT = 4;
	localparam int unsigned HDR_BYTES   = 8;
	localparam int unsigned MIN_ARENA   = 192;
	// size word of a list head and of the end sentry: min chunk, in use
	localparam logic [31:0] SENTRY_HDR  = 32'h0000_0021;
	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

	typedef enum logic [5:0] {
		ST_CLEAR,
		ST_INIT_CHK,
		ST_INIT_HEAD,
		ST_INIT_FIRST0,
		ST_INIT_FIRST1,
		ST_INIT_LAST0,
		ST_INIT_LAST1,
		ST_IDLE,
		ST_A_START,
		ST_A_OUTER,
		ST_A_HEADRD,
		ST_A_INNER,
		ST_A_SIZE,
		ST_A_NEXT,
		ST_A_END,
		ST_A_SPLIT,
		ST_A_SPL0,
		ST_A_SPL1,
		ST_A_SPL2,
		ST_A_MARK,
		ST_F_CHK,
		ST_F_HDR,
		ST_F_PSZ,
		ST_F_PREV,
		ST_F_NEXT,
		ST_F_NEXTCHK,
		ST_F_WR0,
		ST_F_WR1,
		ST_UL_RF,
		ST_UL_RB,
		ST_UL_W1,
		ST_UL_W2,
		ST_LK_R0,
		ST_LK_W0,
		ST_LK_W1,
		ST_LK_R1,
		ST_LK_W2,
		ST_LK_W3,
		ST_RESP
	} state_t;

	// one arena access: byte address is base plus disp through the shared adder
	typedef struct packed {
		logic        we;
		logic        re;
		logic [31:0] base;
		logic [31:0] disp;
		logic [31:0] wdata;
	} mem_req_t;

endpackage

// ===== rtl/sbfa_ram.sv =====
// single-port arena word memory with registered read
// no package dependency
module sbfa_ram #(
	parameter int unsigned DEPTH = 16384,
	parameter int unsigned AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/sbfa_alu.sv =====
// shared address adder: every arena access goes through it
// no package dependency
module sbfa_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);

	assign sum = a + b;

endmodule

// ===== rtl/sbfa_seq.sv =====
// sequencer and datapath registers for alloc, free and free-all
// depends on sbfa_pkg; drives the arena port through a mem_req_t
module sbfa_seq #(
	parameter int unsigned ARENA_BYTES     = 65536,
	parameter int unsigned FREE_LIST_COUNT = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [16:0]        arena_size,
	input  logic               start,
	input  logic [1:0]         req_type,
	input  logic [15:0]        request_size,
	input  logic [15:0]        block_offset,
	output logic               idle,
	output logic               done,
	output logic [1:0]         res_status,
	output logic [15:0]        res_granted,
	output logic [16:0]        count,
	output sbfa_pkg::mem_req_t mem_req,
	input  logic [31:0]        mem_rdata
);

	localparam int unsigned DEPTH      = ARENA_BYTES / 4;
	localparam int unsigned AW         = $clog2(DEPTH);
	localparam int unsigned WALK_LIMIT = ARENA_BYTES / sbfa_pkg::MIN_CHUNK + 1;
	localparam int unsigned SW         = $clog2(WALK_LIMIT + 1);
	localparam int unsigned CW         = $clog2(FREE_LIST_COUNT + 1);
	localparam logic [31:0] FIRST_OFF  = 32'(FREE_LIST_COUNT * sbfa_pkg::MIN_CHUNK);
	localparam logic [31:0] HEAD_SPAN  = 32'((FREE_LIST_COUNT + 1) * sbfa_pkg::MIN_CHUNK);
	localparam logic [31:0] PREV_FLOOR = 32'((FREE_LIST_COUNT - 1) * sbfa_pkg::MIN_CHUNK);
	localparam logic [31:0] ARENA_CAP  = 32'(ARENA_BYTES) & ~32'd3;
	localparam int unsigned MINB_LISTS = (FREE_LIST_COUNT + 2) * sbfa_pkg::MIN_CHUNK;
	localparam logic [31:0] MINB       = 32'((MINB_LISTS > sbfa_pkg::MIN_ARENA) ?
		MINB_LISTS : sbfa_pkg::MIN_ARENA);
	localparam logic [31:0] MINC       = 32'(sbfa_pkg::MIN_CHUNK);

	function automatic logic [CW-1:0] class_of(input logic [31:0] n);
		logic [CW-1:0] r;
		logic          hit;
		r   = CW'(FREE_LIST_COUNT - 1);
		hit = 1'b0;
		for (int l = 0; l < FREE_LIST_COUNT - 1; l++) begin
			if (!hit && n < (MINC << l)) begin
				r   = CW'(l);
				hit = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] head_of(input logic [CW-1:0] cls);
		return 32'(cls) << sbfa_pkg::CHUNK_SHIFT;
	endfunction

	sbfa_pkg::state_t state_q, state_d, ret_q;
	logic [AW-1:0] clr_q;
	logic          valid_q, from_reset_q;
	logic [16:0]   cnt_q;

	logic [15:0]   req_q, off_q, gr_q;
	logic [1:0]    st_q;
	logic [16:0]   nb_q;
	logic [CW-1:0] i_q;
	logic [1:0]    j_q;
	logic [SW-1:0] steps_q;
	logic          exact_q, have_q;
	logic [31:0]   head_q, c_q, best_q, bsz_q, rem_q, q_q, sz_q, last_q;
	logic [31:0]   prev_q, next_q, p_q, ua_q, f_q, b_q, lh_q, lc_q;

	logic [31:0] rd, rsz, nb32, mem_w, c_w;
	logic [16:0] nb_w;
	logic [17:0] nb_sum;
	logic [32:0] cnt_add;
	logic        init_ok, inner_stop, split_ok, f_bad0, f_bad1, rd_free;
	logic [16:0] cnt_alloc, cnt_free;

	assign rd      = mem_rdata;
	assign rsz     = {1'b0, rd[31:1]};
	assign rd_free = (rd[0] == 1'b0);
	assign nb32    = 32'(nb_q);
	assign nb_sum  = 18'(req_q) + 18'd11;
	assign nb_w    = (nb_sum[17:2] < 16'd4) ? 17'(MINC) : {nb_sum[16:2], 2'b00};
	assign mem_w   = ({15'b0, arena_size[16:2], 2'b00} > ARENA_CAP) ? ARENA_CAP :
		{15'b0, arena_size[16:2], 2'b00};
	assign init_ok = (mem_w >= MINB);
	assign inner_stop = (c_q == head_q) || (steps_q >= SW'(WALK_LIMIT)) || exact_q;
	assign split_ok   = ((bsz_q - nb32) >= MINC);
	assign c_w        = 32'(off_q) - 32'(sbfa_pkg::HDR_BYTES);
	assign f_bad0 = (off_q == 16'd0) || !valid_q || (off_q < 16'(sbfa_pkg::HDR_BYTES)) ||
		(off_q[1:0] != 2'b00) || (c_w < FIRST_OFF) || (c_w >= last_q);
	assign f_bad1 = (sz_q < MINC) || (sz_q[1:0] != 2'b00) || (sz_q > last_q - c_q) ||
		(rd[1:0] != 2'b00) || (rd > c_q) || ((c_q - rd) < PREV_FLOOR);
	assign cnt_add   = 33'(cnt_q) + {1'b0, bsz_q};
	assign cnt_alloc = ((bsz_q > 32'(sbfa_pkg::COUNT_MAX)) ||
		(cnt_add > 33'(sbfa_pkg::COUNT_MAX))) ? sbfa_pkg::COUNT_MAX : cnt_add[16:0];
	assign cnt_free  = (32'(cnt_q) > sz_q) ? (cnt_q - sz_q[16:0]) : 17'd0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbfa_pkg::ST_CLEAR:
				if (clr_q == AW'(DEPTH - 1)) state_d = sbfa_pkg::ST_INIT_CHK;
			sbfa_pkg::ST_INIT_CHK:
				state_d = init_ok ? sbfa_pkg::ST_INIT_HEAD :
					(from_reset_q ? sbfa_pkg::ST_IDLE : sbfa_pkg::ST_RESP);
			sbfa_pkg::ST_INIT_HEAD:
				if (j_q == 2'd3 && i_q == CW'(FREE_LIST_COUNT - 1))
					state_d = sbfa_pkg::ST_INIT_FIRST0;
			sbfa_pkg::ST_INIT_FIRST0: state_d = sbfa_pkg::ST_INIT_FIRST1;
			sbfa_pkg::ST_INIT_FIRST1: state_d = sbfa_pkg::ST_LK_R0;
			sbfa_pkg::ST_INIT_LAST0:  state_d = sbfa_pkg::ST_INIT_LAST1;
			sbfa_pkg::ST_INIT_LAST1:
				state_d = from_reset_q ? sbfa_pkg::ST_IDLE : sbfa_pkg::ST_RESP;
			sbfa_pkg::ST_IDLE:
				if (start) begin
					unique case (req_type)
						sbfa_pkg::REQ_ALLOC:    state_d = sbfa_pkg::ST_A_START;
						sbfa_pkg::REQ_FREE:     state_d = sbfa_pkg::ST_F_CHK;
						sbfa_pkg::REQ_FREE_ALL: state_d = sbfa_pkg::ST_INIT_CHK;
						default:                state_d = sbfa_pkg::ST_RESP;
					endcase
				end
			sbfa_pkg::ST_A_START:
				state_d = valid_q ? sbfa_pkg::ST_A_OUTER : sbfa_pkg::ST_RESP;
			sbfa_pkg::ST_A_OUTER:
				state_d = (i_q >= CW'(FREE_LIST_COUNT) || have_q) ?
					sbfa_pkg::ST_A_END : sbfa_pkg::ST_A_HEADRD;
			sbfa_pkg::ST_A_HEADRD: state_d = sbfa_pkg::ST_A_INNER;
			sbfa_pkg::ST_A_INNER:
				state_d = inner_stop ? sbfa_pkg::ST_A_OUTER : sbfa_pkg::ST_A_SIZE;
			sbfa_pkg::ST_A_SIZE: state_d = sbfa_pkg::ST_A_NEXT;
			sbfa_pkg::ST_A_NEXT: state_d = sbfa_pkg::ST_A_INNER;
			sbfa_pkg::ST_A_END:
				state_d = have_q ? sbfa_pkg::ST_UL_RF : sbfa_pkg::ST_RESP;
			sbfa_pkg::ST_A_SPLIT:
				state_d = split_ok ? sbfa_pkg::ST_A_SPL0 : sbfa_pkg::ST_A_MARK;
			sbfa_pkg::ST_A_SPL0: state_d = sbfa_pkg::ST_A_SPL1;
			sbfa_pkg::ST_A_SPL1: state_d = sbfa_pkg::ST_A_SPL2;
			sbfa_pkg::ST_A_SPL2: state_d = sbfa_pkg::ST_LK_R0;
			sbfa_pkg::ST_A_MARK: state_d = sbfa_pkg::ST_RESP;
			sbfa_pkg::ST_F_CHK:
				state_d = f_bad0 ? sbfa_pkg::ST_RESP : sbfa_pkg::ST_F_HDR;
			sbfa_pkg::ST_F_HDR:
				state_d = rd_free ? sbfa_pkg::ST_RESP : sbfa_pkg::ST_F_PSZ;
			sbfa_pkg::ST_F_PSZ:
				state_d = f_bad1 ? sbfa_pkg::ST_RESP : sbfa_pkg::ST_F_PREV;
			sbfa_pkg::ST_F_PREV:
				state_d = rd_free ? sbfa_pkg::ST_UL_RF : sbfa_pkg::ST_F_NEXT;
			sbfa_pkg::ST_F_NEXT: state_d = sbfa_pkg::ST_F_NEXTCHK;
			sbfa_pkg::ST_F_NEXTCHK:
				state_d = rd_free ? sbfa_pkg::ST_UL_RF : sbfa_pkg::ST_F_WR0;
			sbfa_pkg::ST_F_WR0: state_d = sbfa_pkg::ST_F_WR1;
			sbfa_pkg::ST_F_WR1: state_d = sbfa_pkg::ST_LK_R0;
			sbfa_pkg::ST_UL_RF: state_d = sbfa_pkg::ST_UL_RB;
			sbfa_pkg::ST_UL_RB: state_d = sbfa_pkg::ST_UL_W1;
			sbfa_pkg::ST_UL_W1: state_d = sbfa_pkg::ST_UL_W2;
			sbfa_pkg::ST_UL_W2: state_d = ret_q;
			sbfa_pkg::ST_LK_R0: state_d = sbfa_pkg::ST_LK_W0;
			sbfa_pkg::ST_LK_W0: state_d = sbfa_pkg::ST_LK_W1;
			sbfa_pkg::ST_LK_W1: state_d = sbfa_pkg::ST_LK_R1;
			sbfa_pkg::ST_LK_R1: state_d = sbfa_pkg::ST_LK_W2;
			sbfa_pkg::ST_LK_W2: state_d = sbfa_pkg::ST_LK_W3;
			sbfa_pkg::ST_LK_W3: state_d = ret_q;
			sbfa_pkg::ST_RESP:  state_d = sbfa_pkg::ST_IDLE;
			default:            state_d = sbfa_pkg::ST_IDLE;
		endcase
	end

	// arena access for each state
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			sbfa_pkg::ST_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.base = 32'({clr_q, 2'b00});
			end
			sbfa_pkg::ST_INIT_HEAD: begin
				mem_req.we   = 1'b1;
				mem_req.base = head_of(i_q);
				mem_req.disp = 32'({j_q, 2'b00});
				unique case (j_q)
					2'd0:    mem_req.wdata = 32'd0;
					2'd1:    mem_req.wdata = sbfa_pkg::SENTRY_HDR;
					default: mem_req.wdata = head_of(i_q);
				endcase
			end
			sbfa_pkg::ST_INIT_FIRST0: begin
				mem_req.we    = 1'b1;
				mem_req.base  = FIRST_OFF;
				mem_req.wdata = MINC;
			end
			sbfa_pkg::ST_INIT_FIRST1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = FIRST_OFF;
				mem_req.disp  = 32'd4;
				mem_req.wdata = {sz_q[30:0], 1'b0};
			end
			sbfa_pkg::ST_INIT_LAST0: begin
				mem_req.we    = 1'b1;
				mem_req.base  = last_q;
				mem_req.wdata = sz_q;
			end
			sbfa_pkg::ST_INIT_LAST1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = last_q;
				mem_req.disp  = 32'd4;
				mem_req.wdata = sbfa_pkg::SENTRY_HDR;
			end
			sbfa_pkg::ST_A_OUTER: begin
				mem_req.re   = 1'b1;
				mem_req.base = head_of(i_q);
				mem_req.disp = 32'd8;
			end
			sbfa_pkg::ST_A_INNER: begin
				mem_req.re   = 1'b1;
				mem_req.base = c_q;
				mem_req.disp = 32'd4;
			end
			sbfa_pkg::ST_A_SIZE: begin
				mem_req.re   = 1'b1;
				mem_req.base = c_q;
				mem_req.disp = 32'd8;
			end
			sbfa_pkg::ST_A_SPL0: begin
				mem_req.we    = 1'b1;
				mem_req.base  = q_q;
				mem_req.disp  = 32'd4;
				mem_req.wdata = {rem_q[30:0], 1'b0};
			end
			sbfa_pkg::ST_A_SPL1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = q_q;
				mem_req.wdata = nb32;
			end
			sbfa_pkg::ST_A_SPL2: begin
				mem_req.we    = 1'b1;
				mem_req.base  = q_q;
				mem_req.disp  = rem_q;
				mem_req.wdata = rem_q;
			end
			sbfa_pkg::ST_A_MARK: begin
				mem_req.we    = 1'b1;
				mem_req.base  = best_q;
				mem_req.disp  = 32'd4;
				mem_req.wdata = {bsz_q[30:0], 1'b1};
			end
			sbfa_pkg::ST_F_CHK: begin
				mem_req.re   = 1'b1;
				mem_req.base = c_w;
				mem_req.disp = 32'd4;
			end
			sbfa_pkg::ST_F_HDR: begin
				mem_req.re   = 1'b1;
				mem_req.base = c_q;
			end
			sbfa_pkg::ST_F_PSZ: begin
				mem_req.re   = 1'b1;
				mem_req.base = c_q - rd;
				mem_req.disp = 32'd4;
			end
			sbfa_pkg::ST_F_NEXT: begin
				mem_req.re   = 1'b1;
				mem_req.base = next_q;
				mem_req.disp = 32'd4;
			end
			sbfa_pkg::ST_F_WR0: begin
				mem_req.we    = 1'b1;
				mem_req.base  = p_q;
				mem_req.disp  = 32'd4;
				mem_req.wdata = {sz_q[30:0], 1'b0};
			end
			sbfa_pkg::ST_F_WR1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = p_q;
				mem_req.disp  = sz_q;
				mem_req.wdata = sz_q;
			end
			sbfa_pkg::ST_UL_RF: begin
				mem_req.re   = 1'b1;
				mem_req.base = ua_q;
				mem_req.disp = 32'd8;
			end
			sbfa_pkg::ST_UL_RB: begin
				mem_req.re   = 1'b1;
				mem_req.base = ua_q;
				mem_req.disp = 32'd12;
			end
			sbfa_pkg::ST_UL_W1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = f_q;
				mem_req.disp  = 32'd12;
				mem_req.wdata = rd;
			end
			sbfa_pkg::ST_UL_W2: begin
				mem_req.we    = 1'b1;
				mem_req.base  = b_q;
				mem_req.disp  = 32'd8;
				mem_req.wdata = f_q;
			end
			sbfa_pkg::ST_LK_R0, sbfa_pkg::ST_LK_R1: begin
				mem_req.re   = 1'b1;
				mem_req.base = lh_q;
				mem_req.disp = 32'd8;
			end
			sbfa_pkg::ST_LK_W0: begin
				mem_req.we    = 1'b1;
				mem_req.base  = lc_q;
				mem_req.disp  = 32'd8;
				mem_req.wdata = rd;
			end
			sbfa_pkg::ST_LK_W1: begin
				mem_req.we    = 1'b1;
				mem_req.base  = lc_q;
				mem_req.disp  = 32'd12;
				mem_req.wdata = lh_q;
			end
			sbfa_pkg::ST_LK_W2: begin
				mem_req.we    = 1'b1;
				mem_req.base  = rd;
				mem_req.disp  = 32'd12;
				mem_req.wdata = lc_q;
			end
			sbfa_pkg::ST_LK_W3: begin
				mem_req.we    = 1'b1;
				mem_req.base  = lh_q;
				mem_req.disp  = 32'd8;
				mem_req.wdata = lc_q;
			end
			default: mem_req = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbfa_pkg::ST_CLEAR;
			ret_q        <= sbfa_pkg::ST_IDLE;
			clr_q        <= '0;
			valid_q      <= 1'b0;
			from_reset_q <= 1'b1;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sbfa_pkg::ST_CLEAR:      clr_q <= clr_q + AW'(1);
				sbfa_pkg::ST_INIT_CHK:   valid_q <= init_ok;
				sbfa_pkg::ST_INIT_FIRST1: ret_q <= sbfa_pkg::ST_INIT_LAST0;
				sbfa_pkg::ST_IDLE:
					if (start) begin
						from_reset_q <= 1'b0;
						if (req_type == sbfa_pkg::REQ_FREE_ALL) cnt_q <= '0;
					end
				sbfa_pkg::ST_A_END:  ret_q <= sbfa_pkg::ST_A_SPLIT;
				sbfa_pkg::ST_A_SPL2: ret_q <= sbfa_pkg::ST_A_MARK;
				sbfa_pkg::ST_A_MARK: cnt_q <= cnt_alloc;
				sbfa_pkg::ST_F_PSZ:
					if (!f_bad1) cnt_q <= cnt_free;
				sbfa_pkg::ST_F_PREV:    ret_q <= sbfa_pkg::ST_F_NEXT;
				sbfa_pkg::ST_F_NEXTCHK: ret_q <= sbfa_pkg::ST_F_WR0;
				sbfa_pkg::ST_F_WR1:     ret_q <= sbfa_pkg::ST_RESP;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sbfa_pkg::ST_INIT_CHK: begin
				sz_q   <= mem_w - HEAD_SPAN;
				last_q <= mem_w - MINC;
				i_q    <= '0;
				j_q    <= '0;
			end
			sbfa_pkg::ST_INIT_HEAD: begin
				j_q <= j_q + 2'd1;
				if (j_q == 2'd3) i_q <= i_q + CW'(1);
			end
			sbfa_pkg::ST_INIT_FIRST1: begin
				lh_q <= head_of(class_of(sz_q));
				lc_q <= FIRST_OFF;
			end
			sbfa_pkg::ST_IDLE:
				if (start) begin
					req_q <= request_size;
					off_q <= block_offset;
					gr_q  <= '0;
					unique case (req_type)
						sbfa_pkg::REQ_ALLOC:    st_q <= sbfa_pkg::STAT_OOM;
						sbfa_pkg::REQ_FREE_ALL: st_q <= sbfa_pkg::STAT_OK;
						default:                st_q <= sbfa_pkg::STAT_IGN;
					endcase
				end
			sbfa_pkg::ST_A_START: begin
				nb_q   <= nb_w;
				i_q    <= class_of(32'(nb_w));
				have_q <= 1'b0;
				bsz_q  <= '1;
				best_q <= '0;
			end
			sbfa_pkg::ST_A_OUTER: head_q <= head_of(i_q);
			sbfa_pkg::ST_A_HEADRD: begin
				c_q     <= rd;
				steps_q <= '0;
				exact_q <= 1'b0;
			end
			sbfa_pkg::ST_A_INNER:
				if (inner_stop) i_q <= i_q + CW'(1);
			sbfa_pkg::ST_A_SIZE: begin
				if (rsz == nb32) begin
					best_q  <= c_q;
					bsz_q   <= rsz;
					exact_q <= 1'b1;
				end else if (rsz > nb32 && rsz < bsz_q) begin
					best_q <= c_q;
					bsz_q  <= rsz;
				end
				if (rsz >= nb32) have_q <= 1'b1;
			end
			sbfa_pkg::ST_A_NEXT: begin
				c_q     <= rd;
				steps_q <= steps_q + SW'(1);
			end
			sbfa_pkg::ST_A_END: ua_q <= best_q;
			sbfa_pkg::ST_A_SPLIT: begin
				rem_q <= bsz_q - nb32;
				q_q   <= best_q + nb32;
			end
			sbfa_pkg::ST_A_SPL2: begin
				lh_q  <= head_of(class_of(rem_q));
				lc_q  <= q_q;
				bsz_q <= nb32;
			end
			sbfa_pkg::ST_A_MARK: begin
				gr_q <= best_q[15:0] + 16'(sbfa_pkg::HDR_BYTES);
				st_q <= sbfa_pkg::STAT_OK;
			end
			sbfa_pkg::ST_F_CHK: c_q <= c_w;
			sbfa_pkg::ST_F_HDR: sz_q <= rsz;
			sbfa_pkg::ST_F_PSZ: begin
				prev_q <= c_q - rd;
				next_q <= c_q + sz_q;
				p_q    <= c_q;
				if (!f_bad1) st_q <= sbfa_pkg::STAT_OK;
			end
			sbfa_pkg::ST_F_PREV:
				if (rd_free) begin
					sz_q <= sz_q + rsz;
					p_q  <= prev_q;
					ua_q <= prev_q;
				end
			sbfa_pkg::ST_F_NEXTCHK:
				if (rd_free) begin
					sz_q <= sz_q + rsz;
					ua_q <= next_q;
				end
			sbfa_pkg::ST_F_WR1: begin
				lh_q <= head_of(class_of(sz_q));
				lc_q <= p_q;
			end
			sbfa_pkg::ST_UL_RB: f_q <= rd;
			sbfa_pkg::ST_UL_W1: b_q <= rd;
			default: ;
		endcase
	end

	assign idle        = (state_q == sbfa_pkg::ST_IDLE);
	assign done        = (state_q == sbfa_pkg::ST_RESP);
	assign res_status  = st_q;
	assign res_granted = gr_q;
	assign count       = cnt_q;

endmodule

// ===== rtl/segregated_best_fit_allocator_top.sv =====
// top level of the segregated best-fit heap allocator
// depends on sbfa_pkg, sbfa_ram, sbfa_alu and sbfa_seq
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser req_type; tdata request_size, block_offset
// m_*       out  m_tvalid/m_tready  tuser status; tdata granted_offset, bytes_in_use
// cfg_*     in   cfg_we             cfg_wdata arena_size
//
// one request at a time: a free-all rebuilds the free lists unless the arena is too
// small; a free merges each free neighbor, or is ignored; an allocate scans the
// free lists and the free chunks on them, then unlinks the chunk it takes and
// splits it when the rest is large enough; each step is one access of the single
// arena memory port through the shared adder.
// after reset a clearing pass zeroes the arena, then the free lists are built;
// no request is taken meanwhile.
// a result waits in the output register; the next request is taken only
// after it has been consumed.
module segregated_best_fit_allocator_top #(
	parameter int unsigned ARENA_BYTES     = 65536,
	parameter int unsigned FREE_LIST_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] block_offset
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] granted_offset, [32:16] bytes_in_use, zero pad
	output logic [1:0]  m_tuser,   // [1:0] status
	// arena size register
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	localparam int unsigned DEPTH = ARENA_BYTES / 4;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [16:0]        arena_size_q;
	logic               m_valid_q;
	logic               seq_idle, seq_done, start;
	logic [1:0]         res_status;
	logic [15:0]        res_granted;
	logic [16:0]        count;
	sbfa_pkg::mem_req_t mem_req;
	logic [31:0]        addr_sum, mem_rdata;

	// arena size, applied at reset build and at every free-all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_size_q <= 17'h10000;
		end else if (cfg_we) begin
			arena_size_q <= cfg_wdata;
		end
	end

	// result holds until taken; sequencer stays idle meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (seq_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign s_tready = seq_idle && !m_valid_q;
	assign start    = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, count, res_granted};
	assign m_tuser  = res_status;

	sbfa_seq #(
		.ARENA_BYTES     (ARENA_BYTES),
		.FREE_LIST_COUNT (FREE_LIST_COUNT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.arena_size   (arena_size_q),
		.start        (start),
		.req_type     (s_tuser),
		.request_size (s_tdata[15:0]),
		.block_offset (s_tdata[31:16]),
		.idle         (seq_idle),
		.done         (seq_done),
		.res_status   (res_status),
		.res_granted  (res_granted),
		.count        (count),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	// every arena byte address is formed here
	sbfa_alu u_alu (
		.a   (mem_req.base),
		.b   (mem_req.disp),
		.sum (addr_sum)
	);

	// byte address wraps modulo the arena depth
	sbfa_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (addr_sum[AW+1:2]),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

`ifndef NO_ASSERTIONS
	// no request taken while a result is pending
	a_ready_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("request taken with result pending");

	// a taken request keeps the sequencer busy the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready) else $error("sequencer idle right after request");

	// a finished request never overwrites a waiting result
	a_done_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> !m_valid_q) else $error("result overwritten");

	// one memory port: read and write never in the same cycle
	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !mem_req.re) else $error("arena read and write together");
`endif

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the segregated best-fit heap allocator
// depends on sbfa_pkg and segregated_best_fit_allocator_top; a shadow heap predicts each result no directed row gives
module testbench;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int unsigned HEAP_BYTES = 65536;
	localparam int unsigned LISTS      = 10;
	localparam int unsigned DEPTH      = HEAP_BYTES / 4;
	localparam int unsigned CHUNK      = sbfa_pkg::MIN_CHUNK;
	localparam int unsigned HDR        = sbfa_pkg::HDR_BYTES;
	localparam int unsigned WALK_MAX   = HEAP_BYTES / CHUNK + 1;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted;
		logic [16:0] used;
	} reply_t;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] size;
		logic [15:0] offset;
		bit          typed;
		reply_t      want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [16:0] cfg_wdata;

	segregated_best_fit_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// shadow heap
	logic [31:0] heap [DEPTH];
	logic [16:0] heap_used;
	logic [16:0] heap_size_reg;
	bit          heap_ok;
	int unsigned heap_first;
	int unsigned heap_last;

	reply_t      pending_replies[$];
	logic [15:0] live_blocks[$];
	logic [15:0] last_released;
	int unsigned requests_taken;
	int unsigned replies_seen;
	int unsigned mismatches;
	bit          calm;
	bit          drv_typed;
	reply_t      drv_want;

	function automatic logic [31:0] hrd(int unsigned off);
		return heap[(off >> 2) % DEPTH];
	endfunction

	function automatic void hwr(int unsigned off, logic [31:0] v);
		heap[(off >> 2) % DEPTH] = v;
	endfunction

	function automatic int unsigned chunk_bytes(int unsigned c);
		return hrd(c + 4) >> 1;
	endfunction

	function automatic bit chunk_free(int unsigned c);
		return hrd(c + 4) & 1 ? 1'b0 : 1'b1;
	endfunction

	function automatic int unsigned size_class(int unsigned n);
		for (int unsigned l = 0; l + 1 < LISTS; l++)
			if (n < (CHUNK << l))
				return l;
		return LISTS - 1;
	endfunction

	function automatic void list_remove(int unsigned c);
		int unsigned fw, bw;
		fw = hrd(c + 8);
		bw = hrd(c + 12);
		hwr(fw + 12, bw);
		hwr(bw + 8, fw);
	endfunction

	function automatic void list_insert(int unsigned head, int unsigned c);
		hwr(c + 8, hrd(head + 8));
		hwr(c + 12, head);
		hwr(hrd(head + 8) + 12, c);
		hwr(head + 8, c);
	endfunction

	function automatic void heap_build();
		int unsigned span, sz;
		span = heap_size_reg & ~17'd3;
		if (span > HEAP_BYTES)
			span = HEAP_BYTES;
		if (span < sbfa_pkg::MIN_ARENA) begin
			heap_ok = 0;
			return;
		end
		heap_ok = 1;
		for (int unsigned i = 0; i < LISTS; i++) begin
			hwr(i * CHUNK, 0);
			hwr(i * CHUNK + 4, sbfa_pkg::SENTRY_HDR);
			hwr(i * CHUNK + 8, i * CHUNK);
			hwr(i * CHUNK + 12, i * CHUNK);
		end
		heap_first = LISTS * CHUNK;
		sz = span - (LISTS + 1) * CHUNK;
		hwr(heap_first, CHUNK);
		hwr(heap_first + 4, sz << 1);
		list_insert(size_class(sz) * CHUNK, heap_first);
		heap_last = span - CHUNK;
		hwr(heap_last, sz);
		hwr(heap_last + 4, sbfa_pkg::SENTRY_HDR);
	endfunction

	function automatic reply_t heap_alloc(int unsigned req);
		int unsigned need, best, bsz, head, c, steps, s, rem, q;
		bit have, exact;
		reply_t r;
		r = '{sbfa_pkg::STAT_OOM, 16'd0, heap_used};
		best = 0;
		bsz = 32'hFFFF_FFFF;
		have = 0;
		if (!heap_ok)
			return r;
		need = (req + HDR + 3) & ~32'd3;
		if (need < CHUNK)
			need = CHUNK;
		for (int unsigned i = size_class(need); i < LISTS && !have; i++) begin
			head = i * CHUNK;
			c = hrd(head + 8);
			steps = 0;
			exact = 0;
			while (c != head && steps < WALK_MAX && !exact) begin
				s = chunk_bytes(c);
				if (s == need) begin
					best = c; bsz = s; exact = 1;
				end else if (s > need && s < bsz) begin
					best = c; bsz = s;
				end
				if (s >= need)
					have = 1;
				c = hrd(c + 8);
				steps++;
			end
		end
		if (!have)
			return r;
		list_remove(best);
		if (bsz - need >= CHUNK) begin
			rem = bsz - need;
			q = best + need;
			hwr(q + 4, rem << 1);
			hwr(q, need);
			hwr(q + rem, rem);
			list_insert(size_class(rem) * CHUNK, q);
			bsz = need;
		end
		hwr(best + 4, (bsz << 1) | 1);
		if (heap_used + bsz > sbfa_pkg::COUNT_MAX || bsz > sbfa_pkg::COUNT_MAX)
			heap_used = sbfa_pkg::COUNT_MAX;
		else
			heap_used = heap_used + bsz;
		r = '{sbfa_pkg::STAT_OK, 16'(best + HDR), heap_used};
		return r;
	endfunction

	function automatic logic [1:0] heap_release(int unsigned off);
		int unsigned c, sz, psz, prv, nxt, p;
		if (off == 0 || !heap_ok || off < HDR || (off & 3) != 0)
			return sbfa_pkg::STAT_IGN;
		c = off - HDR;
		if (c < heap_first || c >= heap_last || chunk_free(c))
			return sbfa_pkg::STAT_IGN;
		sz = chunk_bytes(c);
		psz = hrd(c);
		if (sz < CHUNK || (sz & 3) != 0 || sz > heap_last - c)
			return sbfa_pkg::STAT_IGN;
		if ((psz & 3) != 0 || psz > c || c - psz < (LISTS - 1) * CHUNK)
			return sbfa_pkg::STAT_IGN;
		heap_used = (heap_used > sz) ? heap_used - sz : 17'd0;
		p = c;
		prv = c - psz;
		nxt = c + sz;
		if (chunk_free(prv)) begin
			sz += chunk_bytes(prv);
			p = prv;
			list_remove(prv);
		end
		if (chunk_free(nxt)) begin
			sz += chunk_bytes(nxt);
			list_remove(nxt);
		end
		hwr(p + 4, sz << 1);
		hwr(p + sz, sz);
		list_insert(size_class(sz) * CHUNK, p);
		return sbfa_pkg::STAT_OK;
	endfunction

	// advances the shadow heap by one request and keeps the list of live blocks
	function automatic reply_t heap_serve(logic [1:0] kind, logic [15:0] size, logic [15:0] off);
		reply_t r;
		r = '{sbfa_pkg::STAT_IGN, 16'd0, heap_used};
		case (kind)
			sbfa_pkg::REQ_ALLOC: begin
				r = heap_alloc(size);
				if (r.status == sbfa_pkg::STAT_OK)
					live_blocks.push_back(r.granted);
			end
			sbfa_pkg::REQ_FREE: begin
				r.status = heap_release(off);
				r.used = heap_used;
				if (r.status == sbfa_pkg::STAT_OK) begin
					foreach (live_blocks[i])
						if (live_blocks[i] == off) begin
							live_blocks.delete(i);
							break;
						end
					last_released = off;
				end
			end
			sbfa_pkg::REQ_FREE_ALL: begin
				heap_build();
				heap_used = 0;
				live_blocks.delete();
				r = '{sbfa_pkg::STAT_OK, 16'd0, 17'd0};
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// accepted requests feed the shadow heap, results are checked against it
	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && s_tvalid && s_tready) begin
			want = heap_serve(s_tuser, s_tdata[15:0], s_tdata[31:16]);
			if (drv_typed)
				want = drv_want;
			pending_replies.push_back(want);
			requests_taken <= requests_taken + 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[15:0], m_tdata[32:16]};
			replies_seen <= replies_seen + 1;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status %0d offset %0d used %0d",
						got.status, got.granted, got.used);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
							want.status, want.granted, want.used,
							got.status, got.granted, got.used);
				end
			end
		end
	end

	// result side stalls
	initial begin
		int unsigned hold, seen;
		m_tready = 1;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				m_tready = 0;
				repeat (hold) @(negedge clk);
				m_tready = 1;
			end
			seen = replies_seen;
			do @(negedge clk); while (replies_seen == seen);
		end
	end

	task automatic send_request(logic [1:0] kind, logic [15:0] size, logic [15:0] off,
		bit typed = 0, reply_t want = '0);
		int unsigned gap, taken;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = kind;
		s_tdata = {off, size};
		drv_typed = typed;
		drv_want = want;
		s_tvalid = 1;
		taken = requests_taken;
		do @(negedge clk); while (requests_taken == taken);
	endtask

	task automatic wait_drained();
		s_tvalid = 0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [15:0] sz, off;
		pick = $urandom_range(0, 99);
		sz = (pick % 10 < 7) ? 16'($urandom_range(0, 64)) :
			(pick % 10 < 9) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
		off = 16'($urandom);
		if (pick < 48) begin
			send_request(sbfa_pkg::REQ_ALLOC, sz, off);
		end else if (pick < 85 && live_blocks.size() != 0) begin
			send_request(sbfa_pkg::REQ_FREE, sz,
				live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
		end else if (pick < 88 && live_blocks.size() != 0) begin
			// near a live block: misaligned or inside a chunk
			send_request(sbfa_pkg::REQ_FREE, sz,
				live_blocks[$urandom_range(0, live_blocks.size() - 1)] +
				16'($urandom_range(1, 12)));
		end else if (pick < 91) begin
			send_request(sbfa_pkg::REQ_FREE, sz, last_released);
		end else if (pick < 95) begin
			send_request(sbfa_pkg::REQ_FREE, sz, off);
		end else if (pick < 97) begin
			send_request(sbfa_pkg::REQ_FREE_ALL, sz, off);
		end else if (pick < 98) begin
			send_request(REQ_UNKNOWN, sz, off);
		end else begin
			send_request(sbfa_pkg::REQ_ALLOC, 16'($urandom), off);
		end
	endtask

	stim_row_t directed[] = '{
		// after reset: the first chunk starts right above the list heads
		'{sbfa_pkg::REQ_ALLOC, 16'd0, 16'd0, 1,
			'{sbfa_pkg::STAT_OK, 16'd168, 17'd16}},
		'{sbfa_pkg::REQ_ALLOC, 16'd65535, 16'd0, 1,
			'{sbfa_pkg::STAT_OOM, 16'd0, 17'd16}},
		'{sbfa_pkg::REQ_FREE, 16'd0, 16'd0, 1,
			'{sbfa_pkg::STAT_IGN, 16'd0, 17'd16}},
		'{sbfa_pkg::REQ_FREE, 16'd0, 16'd3, 1,
			'{sbfa_pkg::STAT_IGN, 16'd0, 17'd16}},
		'{sbfa_pkg::REQ_FREE, 16'd0, 16'd168, 1,
			'{sbfa_pkg::STAT_OK, 16'd0, 17'd0}},
		'{sbfa_pkg::REQ_FREE, 16'd0, 16'd168, 1,
			'{sbfa_pkg::STAT_IGN, 16'd0, 17'd0}},
		'{REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 1,
			'{sbfa_pkg::STAT_IGN, 16'd0, 17'd0}},
		'{sbfa_pkg::REQ_FREE_ALL, 16'd0, 16'd0, 1,
			'{sbfa_pkg::STAT_OK, 16'd0, 17'd0}},
		'{sbfa_pkg::REQ_ALLOC,    16'd0,     16'd0,     0, '0},
		'{sbfa_pkg::REQ_ALLOC,    16'd8,     16'd0,     0, '0},
		'{sbfa_pkg::REQ_ALLOC,    16'd100,   16'd0,     0, '0},
		'{sbfa_pkg::REQ_ALLOC,    16'd5,     16'd0,     0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd184,   0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd4,     0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd188,   0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd65532, 0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'hFFFF,  0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd168,   0, '0},
		'{sbfa_pkg::REQ_ALLOC,    16'd8,     16'd0,     0, '0},
		'{sbfa_pkg::REQ_FREE,     16'd0,     16'd200,   0, '0},
		'{sbfa_pkg::REQ_ALLOC,    16'd65528, 16'd0,     0, '0},
		'{sbfa_pkg::REQ_FREE_ALL, 16'd0,     16'd0,     0, '0}
	};

	// arena sizes per phase: extremes, truncation, saturation and unusable sizes
	logic [16:0] phase_sizes[] = '{17'd192, 17'd1024, 17'd131071, 17'd100, 17'd4099,
		17'd65536, 17'd0, 17'd195, 17'd600, 17'd65535};

	initial begin
		heap_size_reg = 17'd65536;
		heap_used = 0;
		foreach (heap[i])
			heap[i] = 0;
		heap_build();
		s_tvalid = 0; s_tdata = 0; s_tuser = sbfa_pkg::REQ_ALLOC;
		cfg_we = 0; cfg_wdata = 0;
		requests_taken = 0; replies_seen = 0; mismatches = 0;
		last_released = 0; calm = 0; drv_typed = 0; drv_want = '0;
		arst_n = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		foreach (directed[i])
			send_request(directed[i].kind, directed[i].size, directed[i].offset,
				directed[i].typed, directed[i].want);
		drv_typed = 0;
		repeat (150) random_request();

		foreach (phase_sizes[p]) begin
			wait_drained();
			calm = (p % 4 == 3);
			cfg_wdata = (p == 4) ? 17'($urandom_range(192, 65536)) : phase_sizes[p];
			cfg_we = 1;
			@(negedge clk);
			cfg_we = 0;
			heap_size_reg = cfg_wdata;
			// the new size only applies once the heap is rebuilt
			send_request(sbfa_pkg::REQ_ALLOC, 16'd4, 16'd0);
			send_request(sbfa_pkg::REQ_FREE_ALL, 16'd0, 16'd0);
			repeat (158) random_request();
		end
		wait_drained();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
